@@ hdl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, switched off while reset is high
`define TTCE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ttce port check failed");

// concurrent check, also watched while reset is high
`define TTCE_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("ttce reset check failed");

`endif

@@ hdl/ttce_pkg.sv @@
package ttce_pkg;

   // fixed field widths of the transaction payloads
   localparam int CHAR_W      = 8;
   localparam int ROW_FIELD_W = 5;
   localparam int COL_FIELD_W = 7;

   // control bytes
   localparam logic [CHAR_W-1:0] CH_BEL   = 8'd7;
   localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

   // configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_NEWLINE_ON_CR = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AUTO_WRAP     = 1'd1;

   // depth of the command and result queues
   localparam int QDEPTH  = 2;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic                   mode;
      logic [CHAR_W-1:0]      char_code;
      logic [ROW_FIELD_W-1:0] read_row;
      logic [COL_FIELD_W-1:0] read_col;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0]      read_char;
      logic                   wrote_cell;
      logic [ROW_FIELD_W-1:0] write_row;
      logic [COL_FIELD_W-1:0] write_col;
      logic                   bell;
      logic [1:0]             scroll_count;
      logic [ROW_FIELD_W-1:0] cursor_row;
      logic [COL_FIELD_W-1:0] cursor_col;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_READ,
      OP_BELL,
      OP_BS,
      OP_CR,
      OP_LF,
      OP_CHAR
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic [CHAR_W-1:0]      char_code;
      logic [ROW_FIELD_W-1:0] read_row;
      logic [COL_FIELD_W-1:0] read_col;
   } cmd_type;

   typedef struct packed {
      logic newline_on_cr;
      logic auto_wrap;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_LF,
      ST_SCROLL,
      ST_EMIT
   } back_state_type;

endpackage

@@ hdl/text_terminal_char_engine.sv @@
// text-screen character engine
// input side is a queue: drive req_data and push; a transaction is taken when
// push is high and full is low. a byte is either a control code (bell,
// backspace, cr, lf), a printable byte stored at the cursor, or in read mode
// a request for the screen cell at read_row/read_col.
// result side is a queue too: while empty is low the oldest result sits on
// rsp_data and is taken when pop is high. one result per input transaction.
// csr_wr_en/csr_index/csr_wdata write newline_on_cr (0) and auto_wrap (1).
// after reset the screen store is swept to spaces, one cell a cycle, and full
// stays high until the sweep has reached the last cell.
// in the sequencer, reads, bell, backspace and plain bytes go from idle
// straight to emit; a cr, a line feed or a wrap first passes the line-feed
// state, which feeds the lines owed (one more from newline_on_cr), and each
// scroll clears the new bottom row cell by cell through the single write port.
// a result reaches rsp_data once its transaction has passed the command queue
// and the sequencer and has been written into the result queue.
// a two-deep command queue and a two-deep result queue decouple the sides;
// when pop stays low the result queue fills and the sequencer waits, then
// the command queue fills and full rises.
module text_terminal_char_engine #(
   parameter int ROWS = 25,
   parameter int COLS = 80
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  ttce_pkg::req_type                  req_data,
   output logic                               empty,
   input  logic                               pop,
   output ttce_pkg::rsp_type                  rsp_data,
   input  logic                               csr_wr_en,
   input  logic [ttce_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic                               csr_wdata
);

   ttce_pkg::cfg_type cfg_ff, cfg_in;
   ttce_pkg::cmd_type cmd_data;
   logic              cmd_valid;
   logic              cmd_pop;
   logic              init_busy;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            ttce_pkg::CSR_NEWLINE_ON_CR: cfg_in.newline_on_cr = csr_wdata;
            ttce_pkg::CSR_AUTO_WRAP:     cfg_in.auto_wrap     = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ttce_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .init_busy (init_busy),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop)
   );

   ttce_back #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .init_busy (init_busy),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule

@@ hdl/ttce_front.sv @@
module ttce_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  ttce_pkg::req_type req_data,
   input  logic              init_busy,
   output logic              cmd_valid,
   output ttce_pkg::cmd_type cmd_data,
   input  logic              cmd_pop
);

   localparam int QPTR_W = ttce_pkg::QPTR_W;
   localparam int QCNT_W = ttce_pkg::QCNT_W;

   ttce_pkg::cmd_type   q_ff [ttce_pkg::QDEPTH];
   logic [QPTR_W-1:0]   wp_ff, wp_in;
   logic [QPTR_W-1:0]   rp_ff, rp_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   ttce_pkg::cmd_type   cmd_new;
   logic                q_full;
   logic                accept;
   logic                take;

   // classify the incoming byte
   always_comb begin
      cmd_new.char_code = req_data.char_code;
      cmd_new.read_row  = req_data.read_row;
      cmd_new.read_col  = req_data.read_col;
      if (req_data.mode) begin
         cmd_new.op = ttce_pkg::OP_READ;
      end else begin
         case (req_data.char_code)
            ttce_pkg::CH_BEL: cmd_new.op = ttce_pkg::OP_BELL;
            ttce_pkg::CH_BS:  cmd_new.op = ttce_pkg::OP_BS;
            ttce_pkg::CH_CR:  cmd_new.op = ttce_pkg::OP_CR;
            ttce_pkg::CH_LF:  cmd_new.op = ttce_pkg::OP_LF;
            default:          cmd_new.op = ttce_pkg::OP_CHAR;
         endcase
      end
   end

   // command queue control
   assign q_full    = (cnt_ff == QCNT_W'(ttce_pkg::QDEPTH));
   assign full      = q_full | init_busy;
   assign accept    = push & ~full;
   assign cmd_valid = (cnt_ff != '0);
   assign take      = cmd_pop & cmd_valid;
   assign cmd_data  = q_ff[rp_ff];

   always_comb begin
      wp_in  = accept ? wp_ff + QPTR_W'(1) : wp_ff;
      rp_in  = take ? rp_ff + QPTR_W'(1) : rp_ff;
      cnt_in = cnt_ff;
      if (accept && !take) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (take && !accept) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wp_ff] <= cmd_new;
      end
   end

endmodule

@@ hdl/ttce_back.sv @@
module ttce_back #(
   parameter int ROWS = 25,
   parameter int COLS = 80
) (
   input  logic              clock,
   input  logic              reset,
   input  ttce_pkg::cfg_type cfg,
   input  logic              cmd_valid,
   input  ttce_pkg::cmd_type cmd_data,
   output logic              cmd_pop,
   output logic              init_busy,
   output logic              empty,
   input  logic              pop,
   output ttce_pkg::rsp_type rsp_data
);

   localparam int ROW_W    = $clog2(ROWS);
   localparam int COL_W    = $clog2(COLS);
   localparam int ROWSUM_W = ROW_W + 1;
   localparam int CELLS    = ROWS * COLS;
   localparam int ADDR_W   = $clog2(CELLS);
   localparam int CHAR_W   = ttce_pkg::CHAR_W;
   localparam int RROW_W   = ttce_pkg::ROW_FIELD_W;
   localparam int RCOL_W   = ttce_pkg::COL_FIELD_W;
   localparam int QPTR_W   = ttce_pkg::QPTR_W;
   localparam int QCNT_W   = ttce_pkg::QCNT_W;

   ttce_pkg::back_state_type state_ff, state_in;

   logic [ADDR_W-1:0] init_addr_ff, init_addr_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  base_ff, base_in;
   logic [1:0]        lf_pend_ff, lf_pend_in;
   logic [COL_W-1:0]  clr_col_ff, clr_col_in;

   // per-transaction result fields
   logic              rd_ok_ff, rd_ok_in;
   logic              wrote_ff, wrote_in;
   logic [ROW_W-1:0]  wrow_ff, wrow_in;
   logic [COL_W-1:0]  wcol_ff, wcol_in;
   logic              bell_ff, bell_in;
   logic [1:0]        scrolls_ff, scrolls_in;

   // screen store
   logic [CHAR_W-1:0] screen_ff [CELLS];
   logic [CHAR_W-1:0] rd_data_ff;
   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic [CHAR_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [ROW_W-1:0]  sel_row;
   logic [COL_W-1:0]  sel_col;
   logic [ADDR_W-1:0] cell_addr;

   // result queue
   ttce_pkg::rsp_type oq_ff [ttce_pkg::QDEPTH];
   logic [QPTR_W-1:0] owp_ff, orp_ff;
   logic [QCNT_W-1:0] ocnt_ff;
   logic              oq_push;
   logic              oq_take;
   logic              oq_full;
   ttce_pkg::rsp_type rsp_new;

   // logical row to physical row, modulo the screen height
   function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] b,
                                                 input logic [ROW_W-1:0] r);
      logic [ROWSUM_W-1:0] sum;
      sum = {1'b0, b} + {1'b0, r};
      if (sum >= ROWSUM_W'(ROWS)) begin
         sum = sum - ROWSUM_W'(ROWS);
      end
      return sum[ROW_W-1:0];
   endfunction

   assign cell_addr = ADDR_W'(phys_row(base_ff, sel_row)) * ADDR_W'(COLS) + ADDR_W'(sel_col);

   assign init_busy = (state_ff == ttce_pkg::ST_INIT);
   assign oq_full   = (ocnt_ff == QCNT_W'(ttce_pkg::QDEPTH));

   // sequencer: next state and datapath control
   always_comb begin
      state_in     = state_ff;
      init_addr_in = init_addr_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      base_in      = base_ff;
      lf_pend_in   = lf_pend_ff;
      clr_col_in   = clr_col_ff;
      rd_ok_in     = rd_ok_ff;
      wrote_in     = wrote_ff;
      wrow_in      = wrow_ff;
      wcol_in      = wcol_ff;
      bell_in      = bell_ff;
      scrolls_in   = scrolls_ff;
      sel_row      = row_ff;
      sel_col      = col_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = cell_addr;
      mem_wr_data  = ttce_pkg::CH_SPACE;
      mem_rd_en    = 1'b0;
      cmd_pop      = 1'b0;
      oq_push      = 1'b0;

      case (state_ff)
         // clearing pass over the whole store after reset
         ttce_pkg::ST_INIT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = init_addr_ff;
            if (init_addr_ff == ADDR_W'(CELLS - 1)) begin
               state_in = ttce_pkg::ST_IDLE;
            end else begin
               init_addr_in = init_addr_ff + ADDR_W'(1);
            end
         end

         ttce_pkg::ST_IDLE: begin
            if (cmd_valid && !oq_full) begin
               cmd_pop    = 1'b1;
               state_in   = ttce_pkg::ST_EMIT;
               rd_ok_in   = 1'b0;
               wrote_in   = 1'b0;
               wrow_in    = '0;
               wcol_in    = '0;
               bell_in    = 1'b0;
               scrolls_in = 2'd0;
               lf_pend_in = 2'd0;
               case (cmd_data.op)
                  ttce_pkg::OP_READ: begin
                     if (32'(cmd_data.read_row) < ROWS && 32'(cmd_data.read_col) < COLS) begin
                        sel_row   = ROW_W'(cmd_data.read_row);
                        sel_col   = COL_W'(cmd_data.read_col);
                        mem_rd_en = 1'b1;
                        rd_ok_in  = 1'b1;
                     end
                  end
                  ttce_pkg::OP_BELL: begin
                     bell_in = 1'b1;
                  end
                  ttce_pkg::OP_BS: begin
                     if (col_ff != '0) begin
                        col_in = col_ff - COL_W'(1);
                     end
                  end
                  ttce_pkg::OP_CR: begin
                     col_in     = '0;
                     lf_pend_in = {1'b0, cfg.newline_on_cr};
                     state_in   = ttce_pkg::ST_LF;
                  end
                  ttce_pkg::OP_LF: begin
                     lf_pend_in = 2'd1;
                     state_in   = ttce_pkg::ST_LF;
                  end
                  default: begin
                     // printable byte stored at the cursor
                     mem_wr_en   = 1'b1;
                     mem_wr_data = cmd_data.char_code;
                     wrote_in    = 1'b1;
                     wrow_in     = row_ff;
                     wcol_in     = col_ff;
                     if (col_ff != COL_W'(COLS - 1)) begin
                        col_in = col_ff + COL_W'(1);
                     end else if (cfg.auto_wrap) begin
                        col_in     = '0;
                        lf_pend_in = 2'd1 + {1'b0, cfg.newline_on_cr};
                        state_in   = ttce_pkg::ST_LF;
                     end
                  end
               endcase
            end
         end

         // line feeds still owed by this transaction
         ttce_pkg::ST_LF: begin
            if (lf_pend_ff == 2'd0) begin
               state_in = ttce_pkg::ST_EMIT;
            end else if (row_ff != ROW_W'(ROWS - 1)) begin
               row_in     = row_ff + ROW_W'(1);
               lf_pend_in = lf_pend_ff - 2'd1;
            end else begin
               clr_col_in = '0;
               state_in   = ttce_pkg::ST_SCROLL;
            end
         end

         // clear the old top row, one cell a cycle, then move the base
         ttce_pkg::ST_SCROLL: begin
            sel_row   = '0;
            sel_col   = clr_col_ff;
            mem_wr_en = 1'b1;
            if (clr_col_ff == COL_W'(COLS - 1)) begin
               base_in    = (base_ff == ROW_W'(ROWS - 1)) ? '0 : base_ff + ROW_W'(1);
               scrolls_in = scrolls_ff + 2'd1;
               lf_pend_in = lf_pend_ff - 2'd1;
               state_in   = ttce_pkg::ST_LF;
            end else begin
               clr_col_in = clr_col_ff + COL_W'(1);
            end
         end

         ttce_pkg::ST_EMIT: begin
            oq_push  = 1'b1;
            state_in = ttce_pkg::ST_IDLE;
         end

         default: begin
            state_in = ttce_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ttce_pkg::ST_INIT;
         init_addr_ff <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         base_ff      <= '0;
         lf_pend_ff   <= 2'd0;
         clr_col_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         init_addr_ff <= init_addr_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         base_ff      <= base_in;
         lf_pend_ff   <= lf_pend_in;
         clr_col_ff   <= clr_col_in;
      end
   end

   // result fields carry no reset
   always_ff @(posedge clock) begin
      rd_ok_ff   <= rd_ok_in;
      wrote_ff   <= wrote_in;
      wrow_ff    <= wrow_in;
      wcol_ff    <= wcol_in;
      bell_ff    <= bell_in;
      scrolls_ff <= scrolls_in;
   end

   // screen memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         screen_ff[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= screen_ff[cell_addr];
      end
   end

   // assemble the result transaction
   always_comb begin
      rsp_new.read_char    = rd_ok_ff ? rd_data_ff : '0;
      rsp_new.wrote_cell   = wrote_ff;
      rsp_new.write_row    = RROW_W'(wrow_ff);
      rsp_new.write_col    = RCOL_W'(wcol_ff);
      rsp_new.bell         = bell_ff;
      rsp_new.scroll_count = scrolls_ff;
      rsp_new.cursor_row   = RROW_W'(row_ff);
      rsp_new.cursor_col   = RCOL_W'(col_ff);
   end

   // result queue
   assign empty    = (ocnt_ff == '0);
   assign oq_take  = pop & ~empty;
   assign rsp_data = oq_ff[orp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         owp_ff  <= '0;
         orp_ff  <= '0;
         ocnt_ff <= '0;
      end else begin
         if (oq_push) begin
            owp_ff <= owp_ff + QPTR_W'(1);
         end
         if (oq_take) begin
            orp_ff <= orp_ff + QPTR_W'(1);
         end
         if (oq_push && !oq_take) begin
            ocnt_ff <= ocnt_ff + QCNT_W'(1);
         end else if (oq_take && !oq_push) begin
            ocnt_ff <= ocnt_ff - QCNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (oq_push) begin
         oq_ff[owp_ff] <= rsp_new;
      end
   end

endmodule

@@ hdl/ttce_checker.sv @@
`include "assert_macros.svh"

module ttce_checker #(
   parameter int ROWS = 25,
   parameter int COLS = 80
) (
   input logic              clock,
   input logic              reset,
   input logic              push,
   input logic              full,
   input logic              empty,
   input logic              pop,
   input ttce_pkg::rsp_type rsp_data
);

   logic [2:0] pending_ff;
   logic       in_txn;
   logic       out_txn;
   logic       rsp_in_range;

   // transactions taken but not yet answered
   assign in_txn  = push & ~full;
   assign out_txn = pop & ~empty;

   // cursor and written column of the waiting result lie on the screen
   assign rsp_in_range = (rsp_data.cursor_row < ROWS) && (rsp_data.cursor_col < COLS) &&
                         (rsp_data.write_col < COLS);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 3'd0;
      end else if (in_txn && !out_txn) begin
         pending_ff <= pending_ff + 3'd1;
      end else if (out_txn && !in_txn) begin
         pending_ff <= pending_ff - 3'd1;
      end
   end

   `TTCE_ASSERT_ALWAYS(a_reset_blocks, clock, reset |=> full && empty)
   `TTCE_ASSERT(a_no_unasked_result, clock, reset, pending_ff == 3'd0 |-> empty)
   `TTCE_ASSERT(a_cursor_in_range, clock, reset, !empty |-> rsp_in_range)
   `TTCE_ASSERT(a_result_held, clock, reset, !empty && !pop |=> !empty && $stable(rsp_data))

endmodule

bind text_terminal_char_engine ttce_checker #(
   .ROWS (ROWS),
   .COLS (COLS)
) u_ttce_checker (.*);

@@ bench/tb_text_terminal_char_engine.sv @@
module tb_text_terminal_char_engine;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SCREEN_ROWS     = 25;
   localparam int SCREEN_COLS     = 80;
   localparam int RESET_CYCLES    = 7;
   localparam int NUM_PHASES      = 8;
   localparam int PHASE_ITEMS     = 150;
   localparam int TAIL_CYCLES     = 200;
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int CHAR_W          = ttce_pkg::CHAR_W;
   localparam int ROW_FIELD_W     = ttce_pkg::ROW_FIELD_W;
   localparam int COL_FIELD_W     = ttce_pkg::COL_FIELD_W;

   localparam logic MODE_CHAR = 1'b0;
   localparam logic MODE_READ = 1'b1;

   typedef enum {
      BURST_TEXT,
      BURST_LF,
      BURST_CR,
      BURST_BS,
      BURST_BEL,
      BURST_READ,
      BURST_NOISE
   } burst_type;

   typedef struct {
      bit                be_config;
      ttce_pkg::req_type req;
      bit                typed;
      ttce_pkg::rsp_type rsp;
      logic              newline_on_cr;
      logic              auto_wrap;
   } stimulus_row_type;

   // block ports
   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           push      = 1'b0;
   logic                           full;
   ttce_pkg::req_type              req_data  = '0;
   logic                           empty;
   logic                           pop       = 1'b0;
   ttce_pkg::rsp_type              rsp_data;
   logic                           csr_wr_en = 1'b0;
   logic [ttce_pkg::CSR_IDX_W-1:0] csr_index = ttce_pkg::CSR_NEWLINE_ON_CR;
   logic                           csr_wdata = 1'b0;

   // shadow of the screen, cursor and settings
   logic [CHAR_W-1:0] screen_cells [SCREEN_ROWS*SCREEN_COLS];
   int                cur_row;
   int                cur_col;
   int                top_base;
   logic              cfg_newline_on_cr;
   logic              cfg_auto_wrap;

   ttce_pkg::rsp_type expected_results [$];
   stimulus_row_type  directed_rows [$];

   int sender_idle_pct = 0;
   int rsp_stall_pct   = 0;
   int error_count     = 0;
   int cycle_count     = 0;
   int results_seen    = 0;
   int items_sent      = 0;
   int reads_sent      = 0;
   int cells_written   = 0;
   int bells_rung      = 0;
   int scrolls_done    = 0;
   int double_scrolls  = 0;
   int settings_used   = 0;

   burst_type burst_kind = BURST_TEXT;
   int        burst_left = 0;

   text_terminal_char_engine #(
      .ROWS(SCREEN_ROWS),
      .COLS(SCREEN_COLS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // ---------------------------------------------------------------- shadow screen

   function automatic int cell_index(input int row, input int col);
      return ((top_base + row) % SCREEN_ROWS) * SCREEN_COLS + col;
   endfunction

   // move down a row, scrolling when already on the bottom row
   task automatic feed_line(inout int scrolls);
      if (cur_row >= SCREEN_ROWS - 1) begin
         // the old top row is recycled as the blank bottom row
         for (int c = 0; c < SCREEN_COLS; c++) begin
            screen_cells[top_base * SCREEN_COLS + c] = ttce_pkg::CH_SPACE;
         end
         top_base = (top_base + 1) % SCREEN_ROWS;
         cur_row  = SCREEN_ROWS - 1;
         scrolls++;
      end else begin
         cur_row++;
      end
   endtask

   task automatic return_carriage(inout int scrolls);
      cur_col = 0;
      if (cfg_newline_on_cr) begin
         feed_line(scrolls);
      end
   endtask

   // apply one transaction to the shadow screen and work out its result
   task automatic predict_result(input ttce_pkg::req_type r, output ttce_pkg::rsp_type o);
      int scrolls;
      scrolls = 0;
      o = '0;
      if (r.mode == MODE_READ) begin
         reads_sent++;
         if (r.read_row < SCREEN_ROWS && r.read_col < SCREEN_COLS) begin
            o.read_char = screen_cells[cell_index(r.read_row, r.read_col)];
         end
      end else if (r.char_code == ttce_pkg::CH_BEL) begin
         o.bell = 1'b1;
         bells_rung++;
      end else if (r.char_code == ttce_pkg::CH_BS) begin
         if (cur_col > 0) begin
            cur_col--;
         end
      end else if (r.char_code == ttce_pkg::CH_CR) begin
         return_carriage(scrolls);
      end else if (r.char_code == ttce_pkg::CH_LF) begin
         feed_line(scrolls);
      end else begin
         screen_cells[cell_index(cur_row, cur_col)] = r.char_code;
         o.wrote_cell = 1'b1;
         o.write_row  = cur_row[ROW_FIELD_W-1:0];
         o.write_col  = cur_col[COL_FIELD_W-1:0];
         cells_written++;
         if (cur_col < SCREEN_COLS - 1) begin
            cur_col++;
         end else if (cfg_auto_wrap) begin
            return_carriage(scrolls);
            feed_line(scrolls);
         end
      end
      o.scroll_count = scrolls[1:0];
      o.cursor_row   = cur_row[ROW_FIELD_W-1:0];
      o.cursor_col   = cur_col[COL_FIELD_W-1:0];
      scrolls_done += scrolls;
      if (scrolls == 2) begin
         double_scrolls++;
      end
   endtask

   // ---------------------------------------------------------------- driving

   // write both settings, one register per cycle
   task automatic set_config(input logic newline_on_cr, input logic auto_wrap);
      csr_wr_en <= 1'b1;
      csr_index <= ttce_pkg::CSR_NEWLINE_ON_CR;
      csr_wdata <= newline_on_cr;
      @(posedge clock);
      csr_index <= ttce_pkg::CSR_AUTO_WRAP;
      csr_wdata <= auto_wrap;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_newline_on_cr = newline_on_cr;
      cfg_auto_wrap     = auto_wrap;
      settings_used++;
   endtask

   // hold the sender off until every outstanding result has been taken
   task automatic drain_results();
      push <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // offer one transaction and wait for it to be taken; push is left high
   task automatic send_transaction(input ttce_pkg::req_type r, input bit typed,
                                   input ttce_pkg::rsp_type typed_rsp);
      ttce_pkg::rsp_type predicted;
      if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct) begin
            @(posedge clock);
         end
      end
      push     <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (full) begin
         @(posedge clock);
      end
      predict_result(r, predicted);
      expected_results.push_back(typed ? typed_rsp : predicted);
      items_sent++;
   endtask

   // ---------------------------------------------------------------- directed table

   function automatic ttce_pkg::req_type char_item(input logic [CHAR_W-1:0] ch);
      ttce_pkg::req_type r;
      r.mode      = MODE_CHAR;
      r.char_code = ch;
      r.read_row  = '1;
      r.read_col  = '1;
      return r;
   endfunction

   function automatic ttce_pkg::req_type read_item(input int row, input int col,
                                                   input logic [CHAR_W-1:0] ch);
      ttce_pkg::req_type r;
      r.mode      = MODE_READ;
      r.char_code = ch;
      r.read_row  = row[ROW_FIELD_W-1:0];
      r.read_col  = col[COL_FIELD_W-1:0];
      return r;
   endfunction

   function automatic ttce_pkg::rsp_type make_rsp(input logic [CHAR_W-1:0] read_char,
                                        input logic wrote, input int wrow, input int wcol,
                                        input logic bell, input int crow, input int ccol);
      ttce_pkg::rsp_type o;
      o              = '0;
      o.read_char    = read_char;
      o.wrote_cell   = wrote;
      o.write_row    = wrow[ROW_FIELD_W-1:0];
      o.write_col    = wcol[COL_FIELD_W-1:0];
      o.bell         = bell;
      o.cursor_row   = crow[ROW_FIELD_W-1:0];
      o.cursor_col   = ccol[COL_FIELD_W-1:0];
      return o;
   endfunction

   task automatic add_item(input ttce_pkg::req_type r, input bit typed,
                           input ttce_pkg::rsp_type o);
      stimulus_row_type row;
      row           = '{default: '0};
      row.req       = r;
      row.typed     = typed;
      row.rsp       = o;
      directed_rows.push_back(row);
   endtask

   task automatic add_config(input logic newline_on_cr, input logic auto_wrap);
      stimulus_row_type row;
      row               = '{default: '0};
      row.be_config     = 1'b1;
      row.newline_on_cr = newline_on_cr;
      row.auto_wrap     = auto_wrap;
      directed_rows.push_back(row);
   endtask

   task automatic build_directed_table();
      // fresh screen: spaces in range, zero outside it, mode wins over char_code
      add_item(read_item(0, 0, ttce_pkg::CH_LF), 1,
               make_rsp(ttce_pkg::CH_SPACE, 0, 0, 0, 0, 0, 0));
      add_item(read_item(24, 79, 8'hFF), 1,
               make_rsp(ttce_pkg::CH_SPACE, 0, 0, 0, 0, 0, 0));
      add_item(read_item(25, 0, 8'h00),   1, make_rsp(8'h00, 0, 0, 0, 0, 0, 0));
      add_item(read_item(31, 127, ttce_pkg::CH_CR), 1, make_rsp(8'h00, 0, 0, 0, 0, 0, 0));
      add_item(read_item(0, 80, ttce_pkg::CH_BEL),  1, make_rsp(8'h00, 0, 0, 0, 0, 0, 0));
      // backspace at the left edge does nothing, bell only flags
      add_item(char_item(ttce_pkg::CH_BS),  1, make_rsp(8'h00, 0, 0, 0, 0, 0, 0));
      add_item(char_item(ttce_pkg::CH_BEL), 1, make_rsp(8'h00, 0, 0, 0, 1, 0, 0));
      // byte extremes are stored like any printable
      add_item(char_item(8'h00),          1, make_rsp(8'h00, 1, 0, 0, 0, 0, 1));
      add_item(char_item(8'hFF),          1, make_rsp(8'h00, 1, 0, 1, 0, 0, 2));
      add_item(read_item(0, 1, 8'h00),    1, make_rsp(8'hFF, 0, 0, 0, 0, 0, 2));
      add_item(char_item(8'h41),          0, '0);
      add_item(char_item(ttce_pkg::CH_BS), 0, '0);
      add_item(read_item(0, 2, 8'h41),    0, '0);
      add_item(char_item(ttce_pkg::CH_LF), 0, '0);
      add_item(char_item(ttce_pkg::CH_CR), 0, '0);
      add_item(char_item(8'h80),          0, '0);
      // carriage return with line feed
      add_config(1'b1, 1'b0);
      add_item(char_item(ttce_pkg::CH_CR), 0, '0);
      add_item(read_item(0, 0, 8'h20),    0, '0);
      add_config(1'b1, 1'b1);
      add_item(char_item(ttce_pkg::CH_LF), 0, '0);
      add_item(char_item(8'h7F),          0, '0);
      add_item(read_item(3, 0, 8'h00),    0, '0);
      add_config(1'b0, 1'b1);
      add_item(char_item(ttce_pkg::CH_BEL), 0, '0);
      add_item(read_item(24, 0, 8'h00),   0, '0);
   endtask

   // ---------------------------------------------------------------- random traffic

   // bursts of text, line feeds, carriage returns, backspaces, bells and reads so
   // the cursor reaches the last column and the bottom row; a little pure noise on top
   task automatic next_random_item(output ttce_pkg::req_type r);
      int roll;
      if (burst_left == 0) begin
         roll = $urandom_range(99);
         if (roll < 40) begin
            burst_kind = BURST_TEXT;
            burst_left = $urandom_range(1, 90);
         end else if (roll < 55) begin
            burst_kind = BURST_LF;
            burst_left = $urandom_range(1, 30);
         end else if (roll < 62) begin
            burst_kind = BURST_CR;
            burst_left = $urandom_range(1, 2);
         end else if (roll < 68) begin
            burst_kind = BURST_BS;
            burst_left = $urandom_range(1, 6);
         end else if (roll < 72) begin
            burst_kind = BURST_BEL;
            burst_left = 1;
         end else if (roll < 90) begin
            burst_kind = BURST_READ;
            burst_left = $urandom_range(1, 8);
         end else begin
            burst_kind = BURST_NOISE;
            burst_left = $urandom_range(1, 4);
         end
      end
      burst_left--;
      r.mode      = MODE_CHAR;
      r.char_code = CHAR_W'($urandom_range(0, 255));
      r.read_row  = ROW_FIELD_W'($urandom_range(0, 31));
      r.read_col  = COL_FIELD_W'($urandom_range(0, 127));
      case (burst_kind)
         BURST_TEXT: begin
            if ($urandom_range(7) != 0) begin
               r.char_code = CHAR_W'($urandom_range(32, 126));
            end
         end
         BURST_LF:  r.char_code = ttce_pkg::CH_LF;
         BURST_CR:  r.char_code = ttce_pkg::CH_CR;
         BURST_BS:  r.char_code = ttce_pkg::CH_BS;
         BURST_BEL: r.char_code = ttce_pkg::CH_BEL;
         BURST_READ: begin
            r.mode = MODE_READ;
            if ($urandom_range(7) != 0) begin
               r.read_row = ROW_FIELD_W'($urandom_range(0, SCREEN_ROWS - 1));
               r.read_col = COL_FIELD_W'($urandom_range(0, SCREEN_COLS - 1));
            end
         end
         default: r.mode = 1'($urandom_range(0, 1));
      endcase
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_error(input string msg);
      $display("ERROR at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   task automatic compare_field(input string name, input logic [7:0] got,
                                input logic [7:0] want);
      if (got !== want) begin
         report_error($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                results_seen, name, got, want));
      end
   endtask

   task automatic check_result(input ttce_pkg::rsp_type got);
      ttce_pkg::rsp_type want;
      if (expected_results.size() == 0) begin
         report_error($sformatf("result 0x%0h with no transaction outstanding", got));
      end else begin
         want = expected_results.pop_front();
         compare_field("read_char",    got.read_char,        want.read_char);
         compare_field("wrote_cell",   8'(got.wrote_cell),   8'(want.wrote_cell));
         compare_field("write_row",    8'(got.write_row),    8'(want.write_row));
         compare_field("write_col",    8'(got.write_col),    8'(want.write_col));
         compare_field("bell",         8'(got.bell),         8'(want.bell));
         compare_field("scroll_count", 8'(got.scroll_count), 8'(want.scroll_count));
         compare_field("cursor_row",   8'(got.cursor_row),   8'(want.cursor_row));
         compare_field("cursor_col",   8'(got.cursor_col),   8'(want.cursor_col));
      end
      results_seen++;
   endtask

   // result side: take and check, stall at random
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && pop && !empty) begin
            check_result(rsp_data);
         end
         pop <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // watchdog
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("== FAIL ==");
      $finish;
   end

   // ---------------------------------------------------------------- main sequence

   initial begin
      ttce_pkg::req_type item;
      for (int i = 0; i < SCREEN_ROWS * SCREEN_COLS; i++) begin
         screen_cells[i] = ttce_pkg::CH_SPACE;
      end
      cur_row           = 0;
      cur_col           = 0;
      top_base          = 0;
      cfg_newline_on_cr = 1'b0;
      cfg_auto_wrap     = 1'b0;
      build_directed_table();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_config(1'b0, 1'b0);

      // directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].be_config) begin
            drain_results();
            set_config(directed_rows[i].newline_on_cr, directed_rows[i].auto_wrap);
         end else begin
            send_transaction(directed_rows[i].req, directed_rows[i].typed,
                             directed_rows[i].rsp);
         end
      end

      // random phases: each setting twice, idling pattern rotating
      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_results();
         set_config(p[1], p[2]);
         case (p % 4)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 84; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 84; end
            default: begin sender_idle_pct = 18; rsp_stall_pct = 18; end
         endcase
         repeat (PHASE_ITEMS) begin
            next_random_item(item);
            send_transaction(item, 1'b0, '0);
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d transactions in %0d cycles: %0d reads, %0d cells written, %0d bells",
               items_sent, cycle_count, reads_sent, cells_written, bells_rung);
      $display("%0d scrolls (%0d double, from wrap with cr line feed), %0d csr settings",
               scrolls_done, double_scrolls, settings_used);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ text_terminal_char_engine.f @@
+incdir+hdl
hdl/ttce_pkg.sv
hdl/ttce_front.sv
hdl/ttce_back.sv
hdl/text_terminal_char_engine.sv
hdl/ttce_checker.sv
bench/tb_text_terminal_char_engine.sv
